### rtl/core/mvbd_pkg.sv
package mvbd_pkg;

  localparam int DEF_NUM_BUTTONS   = 2;
  localparam int DEF_SAMPLE_WINDOW = 8;

  typedef enum logic [1:0] {
    OP_EDGE  = 2'd0,
    OP_TICK  = 2'd1,
    OP_CLEAR = 2'd2
  } op_t;

  // per-button control derived from one item
  typedef struct packed {
    logic edge_hit;
    logic tick;
    logic pin;
    logic clr_hit;
  } lane_cmd_t;

  // per-button state after the update of one item
  typedef struct packed {
    logic active;
    logic level;
    logic evt;
    logic wake;
  } lane_status_t;

endpackage

### rtl/core/majority_vote_button_debouncer.sv
// channel  | handshake           | payload
// input    | in_valid, in_ready  | opcode, edge_mask, pin_levels, clear_mask
// output   | out_valid, out_ready| stable_levels, press_events, busy_mask, wake
//
// one item per cycle while the output is not stalled; each item is held in the input register,
// then its per-button update is registered into the result register
// rst is synchronous: all buttons released, nothing busy, no events, counts zero
// a stalled output holds its result; the input register keeps taking items
// until it too is full, then in_ready drops
module majority_vote_button_debouncer import mvbd_pkg::*; #(
  parameter int NUM_BUTTONS   = DEF_NUM_BUTTONS,
  parameter int SAMPLE_WINDOW = DEF_SAMPLE_WINDOW
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [1:0]             opcode,
  input  logic [NUM_BUTTONS-1:0] edge_mask,
  input  logic [NUM_BUTTONS-1:0] pin_levels,
  input  logic [NUM_BUTTONS-1:0] clear_mask,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [NUM_BUTTONS-1:0] stable_levels,
  output logic [NUM_BUTTONS-1:0] press_events,
  output logic [NUM_BUTTONS-1:0] busy_mask,
  output logic                   wake
);

  logic                   held_valid;
  op_t                    held_op;
  logic [NUM_BUTTONS-1:0] held_edge;
  logic [NUM_BUTTONS-1:0] held_pins;
  logic [NUM_BUTTONS-1:0] held_clear;
  logic                   advance;
  logic                   is_edge;
  logic                   is_tick;
  logic                   is_clear;
  lane_status_t           lane_next [NUM_BUTTONS];
  logic [NUM_BUTTONS-1:0] level_next;
  logic [NUM_BUTTONS-1:0] evt_next;
  logic [NUM_BUTTONS-1:0] active_next;
  logic [NUM_BUTTONS-1:0] wake_bits;

  assign advance = held_valid && (!out_valid || out_ready);

  mvbd_in_reg #(.NUM_BUTTONS(NUM_BUTTONS)) u_in_reg (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .opcode     (opcode),
    .edge_mask  (edge_mask),
    .pin_levels (pin_levels),
    .clear_mask (clear_mask),
    .take       (advance),
    .held_valid (held_valid),
    .held_op    (held_op),
    .held_edge  (held_edge),
    .held_pins  (held_pins),
    .held_clear (held_clear)
  );

  always_comb begin
    is_edge  = 1'b0;
    is_tick  = 1'b0;
    is_clear = 1'b0;
    unique case (held_op)
      OP_EDGE:  is_edge  = 1'b1;
      OP_TICK:  is_tick  = 1'b1;
      OP_CLEAR: is_clear = 1'b1;
      default:  ;  // unused opcode leaves the state alone
    endcase
  end

  for (genvar b = 0; b < NUM_BUTTONS; b++) begin : g_lane
    lane_cmd_t cmd;

    assign cmd = '{edge_hit: is_edge && held_edge[b],
                   tick:     is_tick,
                   pin:      held_pins[b],
                   clr_hit:  is_clear && held_clear[b]};

    mvbd_lane #(.SAMPLE_WINDOW(SAMPLE_WINDOW)) u_lane (
      .clk         (clk),
      .rst         (rst),
      .step        (advance),
      .cmd         (cmd),
      .status_next (lane_next[b])
    );

    assign level_next[b]  = lane_next[b].level;
    assign evt_next[b]    = lane_next[b].evt;
    assign active_next[b] = lane_next[b].active;
    assign wake_bits[b]   = lane_next[b].wake;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      stable_levels <= level_next;
      press_events  <= evt_next;
      busy_mask     <= active_next;
      wake          <= |wake_bits;
    end
  end

endmodule

### rtl/core/mvbd_in_reg.sv
module mvbd_in_reg import mvbd_pkg::*; #(
  parameter int NUM_BUTTONS = DEF_NUM_BUTTONS
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [1:0]             opcode,
  input  logic [NUM_BUTTONS-1:0] edge_mask,
  input  logic [NUM_BUTTONS-1:0] pin_levels,
  input  logic [NUM_BUTTONS-1:0] clear_mask,
  input  logic                   take,
  output logic                   held_valid,
  output op_t                    held_op,
  output logic [NUM_BUTTONS-1:0] held_edge,
  output logic [NUM_BUTTONS-1:0] held_pins,
  output logic [NUM_BUTTONS-1:0] held_clear
);

  assign in_ready = !held_valid || take;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (in_ready) begin
      held_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      held_op    <= op_t'(opcode);
      held_edge  <= edge_mask;
      held_pins  <= pin_levels;
      held_clear <= clear_mask;
    end
  end

endmodule

### rtl/core/mvbd_lane.sv
module mvbd_lane import mvbd_pkg::*; #(
  parameter int SAMPLE_WINDOW = DEF_SAMPLE_WINDOW
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         step,
  input  lane_cmd_t    cmd,
  output lane_status_t status_next
);

  localparam int HALF  = SAMPLE_WINDOW / 2;
  localparam int CNT_W = $clog2(HALF + 2);
  localparam logic [CNT_W-1:0] HALF_C = CNT_W'(HALF);

  logic             active;
  logic             level;
  logic             evt;
  logic [CNT_W-1:0] lo_cnt;
  logic [CNT_W-1:0] hi_cnt;

  logic             sampling;
  logic [CNT_W-1:0] lo_inc;
  logic [CNT_W-1:0] hi_inc;
  logic             done;
  logic             press;
  logic             release_hit;
  logic             active_next;
  logic             level_next;
  logic             evt_next;
  logic [CNT_W-1:0] lo_cnt_next;
  logic [CNT_W-1:0] hi_cnt_next;

  always_comb begin
    sampling    = cmd.tick && active;
    lo_inc      = lo_cnt + CNT_W'(sampling && !cmd.pin);
    hi_inc      = hi_cnt + CNT_W'(sampling && cmd.pin);
    done        = sampling && ((lo_inc > HALF_C) || (hi_inc > HALF_C));
    // majority only flips the level when it disagrees with it
    press       = done && level && (lo_inc > hi_inc);
    release_hit = done && !level && (hi_inc > lo_inc);
    active_next = done ? 1'b0 : (active || cmd.edge_hit);
    level_next  = press ? 1'b0 : (release_hit ? 1'b1 : level);
    evt_next    = (evt && !cmd.clr_hit) || press;
    lo_cnt_next = done ? '0 : lo_inc;
    hi_cnt_next = done ? '0 : hi_inc;
    status_next = '{active: active_next, level: level_next, evt: evt_next, wake: press};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      level  <= 1'b1;
      evt    <= 1'b0;
      lo_cnt <= '0;
      hi_cnt <= '0;
    end else if (step) begin
      active <= active_next;
      level  <= level_next;
      evt    <= evt_next;
      lo_cnt <= lo_cnt_next;
      hi_cnt <= hi_cnt_next;
    end
  end

endmodule

### rtl/core/mvbd_checker.sv
module mvbd_checker import mvbd_pkg::*; #(
  parameter int NUM_BUTTONS = DEF_NUM_BUTTONS
) (
  input logic                   clk,
  input logic                   rst,
  input logic                   in_valid,
  input logic                   in_ready,
  input logic                   out_valid,
  input logic                   out_ready,
  input logic [NUM_BUTTONS-1:0] stable_levels,
  input logic [NUM_BUTTONS-1:0] press_events,
  input logic [NUM_BUTTONS-1:0] busy_mask,
  input logic                   wake
);

  // a wake comes with a pressed button whose event bit is set
  a_wake_has_press: assert property (@(posedge clk) disable iff (rst)
    out_valid && wake |-> (press_events & ~stable_levels) != '0)
    else $error("wake without a registered press");

  // input only backs up when the result register is full and stalled
  a_stall_source: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> out_valid && !out_ready)
    else $error("input stalled without output backpressure");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(stable_levels)
      && $stable(press_events) && $stable(busy_mask) && $stable(wake))
    else $error("stalled result changed");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid right after reset");

endmodule

bind majority_vote_button_debouncer mvbd_checker #(.NUM_BUTTONS(NUM_BUTTONS)) u_mvbd_checker (
  .clk           (clk),
  .rst           (rst),
  .in_valid      (in_valid),
  .in_ready      (in_ready),
  .out_valid     (out_valid),
  .out_ready     (out_ready),
  .stable_levels (stable_levels),
  .press_events  (press_events),
  .busy_mask     (busy_mask),
  .wake          (wake)
);

### tb/majority_vote_button_debouncer_tb.sv
module majority_vote_button_debouncer_tb;
  import mvbd_pkg::*;

  localparam int NB          = DEF_NUM_BUTTONS;
  localparam int HALF_WINDOW = DEF_SAMPLE_WINDOW / 2;
  localparam int HOLD_CYCLES = 200;
  localparam int STALL_LIMIT = 4000;
  localparam int DRAIN_CYCLES = 8;

  // opcode value with no operation behind it
  localparam logic [1:0] OP_UNUSED = 2'd3;

  typedef struct packed {
    logic [NB-1:0] levels;
    logic [NB-1:0] events;
    logic [NB-1:0] busy;
    logic          wake;
  } btn_status_t;

  logic          clk = 1'b0;
  logic          rst = 1'b1;
  logic          in_valid = 1'b0;
  logic          in_ready;
  logic [1:0]    opcode = OP_UNUSED;
  logic [NB-1:0] edge_mask = '0;
  logic [NB-1:0] pin_levels = '0;
  logic [NB-1:0] clear_mask = '0;
  logic          out_valid;
  logic          out_ready = 1'b0;
  logic [NB-1:0] stable_levels;
  logic [NB-1:0] press_events;
  logic [NB-1:0] busy_mask;
  logic          wake;

  // predicted button state
  logic [NB-1:0] pred_busy;
  logic [NB-1:0] pred_level;
  logic [NB-1:0] pred_events;
  logic [2:0]    pred_lows [NB];
  logic [2:0]    pred_highs[NB];

  btn_status_t status_q[$];
  btn_status_t want;

  int send_idle  = 0;
  int recv_stall = 0;
  int hold_reqs  = 0;
  int holds_done = 0;
  int errors     = 0;
  int n_items    = 0;
  int n_results  = 0;
  int n_wakes    = 0;
  int idle_cycles = 0;

  majority_vote_button_debouncer i_dut (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .opcode        (opcode),
    .edge_mask     (edge_mask),
    .pin_levels    (pin_levels),
    .clear_mask    (clear_mask),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .stable_levels (stable_levels),
    .press_events  (press_events),
    .busy_mask     (busy_mask),
    .wake          (wake)
  );

  always #4 clk = ~clk;

  task automatic debounce_update(input logic [1:0] op, input logic [NB-1:0] edges,
                                 input logic [NB-1:0] pins, input logic [NB-1:0] clr);
    btn_status_t res;
    logic woke;
    woke = 1'b0;
    case (op)
      OP_EDGE: pred_busy |= edges;
      OP_TICK: begin
        for (int b = 0; b < NB; b++) begin
          if (pred_busy[b]) begin
            if (pins[b]) pred_highs[b]++;
            else pred_lows[b]++;
            if (pred_lows[b] > HALF_WINDOW || pred_highs[b] > HALF_WINDOW) begin
              pred_busy[b] = 1'b0;
              if (pred_level[b] && pred_lows[b] > pred_highs[b]) begin
                pred_level[b]  = 1'b0;
                pred_events[b] = 1'b1;
                woke = 1'b1;
              end else if (!pred_level[b] && pred_highs[b] > pred_lows[b]) begin
                pred_level[b] = 1'b1;
              end
              pred_lows[b]  = '0;
              pred_highs[b] = '0;
            end
          end
        end
      end
      OP_CLEAR: pred_events &= ~clr;
      default: ;
    endcase
    res.levels = pred_level;
    res.events = pred_events;
    res.busy   = pred_busy;
    res.wake   = woke;
    status_q.push_back(res);
  endtask

  // input monitor: every accepted item feeds the predictor
  always @(posedge clk) begin
    if (!rst && in_valid && in_ready) begin
      debounce_update(opcode, edge_mask, pin_levels, clear_mask);
      n_items++;
    end
  end

  // output checker
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      n_results++;
      if (wake) n_wakes++;
      if (status_q.size() == 0) begin
        errors++;
        $display("%0t: result with nothing expected: levels %b events %b busy %b wake %b",
                 $time, stable_levels, press_events, busy_mask, wake);
      end else begin
        want = status_q.pop_front();
        if (stable_levels !== want.levels) begin
          errors++;
          $display("%0t: stable_levels expected %b actual %b", $time, want.levels,
                   stable_levels);
        end
        if (press_events !== want.events) begin
          errors++;
          $display("%0t: press_events expected %b actual %b", $time, want.events,
                   press_events);
        end
        if (busy_mask !== want.busy) begin
          errors++;
          $display("%0t: busy_mask expected %b actual %b", $time, want.busy, busy_mask);
        end
        if (wake !== want.wake) begin
          errors++;
          $display("%0t: wake expected %b actual %b", $time, want.wake, wake);
        end
      end
    end
  end

  // receiver: random stalls, plus a long hold-off when one is requested
  initial begin
    forever begin
      @(posedge clk);
      if (hold_reqs != holds_done) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES - 1) @(posedge clk);
        holds_done++;
      end else begin
        out_ready <= ($urandom_range(99) >= recv_stall);
      end
    end
  end

  // watchdog on cycles with no handshake on either side
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("majority_vote_button_debouncer regression: fail");
        $finish;
      end
    end
  end

  task automatic send_item(input logic [1:0] op, input logic [NB-1:0] edges,
                           input logic [NB-1:0] pins, input logic [NB-1:0] clr);
    int gap;
    gap = 0;
    while ($urandom_range(99) < send_idle) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid   <= 1'b1;
    opcode     <= op;
    edge_mask  <= edges;
    pin_levels <= pins;
    clear_mask <= clr;
    @(negedge clk);
    while (!in_ready) @(negedge clk);
    @(posedge clk);
  endtask

  // mostly coherent press/release runs on each button, with noisy and random pins
  task automatic run_random(input int count);
    logic [NB-1:0] target;
    logic [NB-1:0] noise;
    logic [NB-1:0] pins;
    logic [1:0]    op;
    int            r;
    target = '1;
    for (int k = 0; k < count; k++) begin
      if ($urandom_range(99) < 6) target ^= NB'($urandom);
      noise = '0;
      for (int b = 0; b < NB; b++) noise[b] = ($urandom_range(99) < 15);
      pins = ($urandom_range(99) < 10) ? NB'($urandom) : (target ^ noise);
      r = $urandom_range(99);
      if (r < 14) op = OP_EDGE;
      else if (r < 80) op = OP_TICK;
      else if (r < 92) op = OP_CLEAR;
      else op = OP_UNUSED;
      send_item(op, NB'($urandom), pins, NB'($urandom));
    end
  endtask

  task automatic test_directed();
    send_idle  = 0;
    recv_stall = 0;
    // reset state, unused opcode, clear with nothing set
    send_item(OP_UNUSED, 2'b11, 2'b11, 2'b11);
    send_item(OP_CLEAR,  2'b11, 2'b00, 2'b11);
    // press both buttons; a tick with nothing busy does nothing
    send_item(OP_TICK,   2'b11, 2'b00, 2'b11);
    send_item(OP_EDGE,   2'b11, 2'b00, 2'b11);
    repeat (3) send_item(OP_TICK, 2'b11, 2'b00, 2'b11);
    // edge on a busy button keeps its counts
    send_item(OP_EDGE,   2'b01, 2'b11, 2'b00);
    repeat (2) send_item(OP_TICK, 2'b00, 2'b00, 2'b00);
    send_item(OP_TICK,   2'b00, 2'b00, 2'b00);
    send_item(OP_CLEAR,  2'b10, 2'b11, 2'b01);
    // release button 1, button 0 stays pressed with no edge
    send_item(OP_EDGE,   2'b10, 2'b00, 2'b11);
    repeat (5) send_item(OP_TICK, 2'b01, 2'b10, 2'b11);
    // mixed: button 0 pressed sees highs, button 1 released sees lows
    send_item(OP_EDGE,   2'b11, 2'b00, 2'b00);
    repeat (5) send_item(OP_TICK, 2'b00, 2'b01, 2'b00);
    // majority agrees with the current level: no change, no event
    send_item(OP_EDGE,   2'b11, 2'b00, 2'b00);
    repeat (5) send_item(OP_TICK, 2'b11, 2'b01, 2'b11);
    send_item(OP_CLEAR,  2'b00, 2'b00, 2'b11);
    send_item(OP_UNUSED, 2'b00, 2'b00, 2'b00);
  endtask

  task automatic test_no_idle();
    send_idle  = 0;
    recv_stall = 0;
    run_random(400);
  endtask

  task automatic test_sender_idle();
    send_idle  = 83;
    recv_stall = 0;
    run_random(400);
  endtask

  task automatic test_receiver_stall();
    send_idle  = 0;
    recv_stall = 83;
    run_random(400);
  endtask

  task automatic test_both_idle();
    send_idle  = 20;
    recv_stall = 20;
    run_random(400);
  endtask

  task automatic test_output_holdoff();
    send_idle  = 0;
    recv_stall = 0;
    hold_reqs++;
    run_random(24);
  endtask

  initial begin
    pred_busy   = '0;
    pred_level  = '1;
    pred_events = '0;
    for (int b = 0; b < NB; b++) begin
      pred_lows[b]  = '0;
      pred_highs[b] = '0;
    end
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    test_directed();
    test_no_idle();
    test_sender_idle();
    test_receiver_stall();
    test_both_idle();
    test_output_holdoff();

    in_valid   <= 1'b0;
    recv_stall = 0;
    while (status_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("sent %0d items, checked %0d results, %0d of them with wake set",
             n_items, n_results, n_wakes);
    $display("phases: directed cases, no idling, idle sender, stalling receiver, both, hold-off");
    if (errors == 0 && status_q.size() == 0) begin
      $display("majority_vote_button_debouncer regression: pass");
    end else begin
      $display("majority_vote_button_debouncer regression: fail");
    end
    $finish;
  end

endmodule

### majority_vote_button_debouncer.f
rtl/core/mvbd_pkg.sv
rtl/core/mvbd_in_reg.sv
rtl/core/mvbd_lane.sv
rtl/core/majority_vote_button_debouncer.sv
rtl/core/mvbd_checker.sv
tb/majority_vote_button_debouncer_tb.sv
